@@ rtl/core/matrix3x3_inverse_top_assert.svh @@
// Assertion macros for the 3x3 inverse core; clk and rst_n are taken from the using module.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a consequent in the same cycle as its antecedent.
`define MI3_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check a consequent in the cycle after its antecedent.
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MI3_ASSERT_IMPL(lbl, ante, cons)
`define MI3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/mi3_pkg.sv @@
`timescale 1ns / 1ps
package mi3_pkg;

    localparam int NLANE = 9;
    localparam int M_W   = 24;
    localparam int PRD_W = 48;
    localparam int ADJ_W = 49;
    localparam int NUM_W = 48;
    localparam int DIV_W = 32;
    localparam int RES_W = 32;
    localparam int LO_W  = 57;
    localparam int HI_W  = 41;
    localparam int DET_W = 74;
    localparam int FRONT = 8;

    // Cofactor k = m[CA]*m[CB] - m[CC]*m[CD], already transposed
    localparam int unsigned CA [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned CB [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned CC [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned CD [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    // Adjugate entries that pair with row 0 for the determinant
    localparam int unsigned DJ [3] = '{0, 3, 6};

    typedef struct packed {
        logic                            act;
        logic [RES_W-1:0]                gdet;
        logic [NLANE-1:0][NUM_W-1:0]     nmag;
        logic [NLANE-1:0]                nneg;
    } mi3_side_t;

    typedef struct packed {
        logic [NLANE-1:0][DIV_W-1:0]     rem;
        logic [NLANE-1:0][NUM_W-1:0]     nq;
        logic [DIV_W-1:0]                d;
        logic                            dneg;
        logic [NLANE-1:0]                nneg;
        logic                            sing;
        logic [RES_W-1:0]                det;
        logic                            clip;
    } mi3_div_t;

    typedef struct packed {
        logic [NLANE-1:0][RES_W-1:0]     r;
        logic [RES_W-1:0]                det;
        logic                            sing;
        logic                            sat;
    } mi3_res_t;

    // Apply sign and clip a magnitude to 32-bit signed; returns {clip, value}
    function automatic logic [RES_W:0] sat32(input logic neg, input logic big,
                                             input logic [RES_W-1:0] m);
        logic [RES_W-1:0] v;
        logic             c;
        if (neg)
        begin
            c = big || (m > 32'h8000_0000);
            v = c ? 32'h8000_0000 : (~m + 32'd1);
        end
        else
        begin
            c = big || m[RES_W-1];
            v = c ? 32'h7fff_ffff : m;
        end
        return {c, v};
    endfunction

endpackage

@@ rtl/core/mi3_div.sv @@
`timescale 1ns / 1ps
module mi3_div
    import mi3_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  mi3_div_t din,
    output mi3_div_t dout
);

    mi3_div_t st_reg  [NUM_W];
    mi3_div_t st_next [NUM_W];

    // One restoring quotient bit per stage, all nine lanes share the divisor
    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_st
            mi3_div_t         src;
            logic [DIV_W:0]   cur  [NLANE];
            logic [DIV_W+1:0] diff [NLANE];

            if (i == 0)
            begin : g_first
                assign src = din;
            end
            else
            begin : g_rest
                assign src = st_reg[i-1];
            end

            always_comb
            begin
                st_next[i] = src;
                for (int l = 0; l < NLANE; l++)
                begin
                    cur[l]  = {src.rem[l], src.nq[l][NUM_W-1]};
                    diff[l] = {1'b0, cur[l]} - {2'b00, src.d};
                    if (!diff[l][DIV_W+1])
                    begin
                        st_next[i].rem[l] = diff[l][DIV_W-1:0];
                        st_next[i].nq[l]  = {src.nq[l][NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next[i].rem[l] = cur[l][DIV_W-1:0];
                        st_next[i].nq[l]  = {src.nq[l][NUM_W-2:0], 1'b0};
                    end
                end
            end

            // Advance with the pipeline
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[i] <= st_next[i];
                end
            end
        end
    endgenerate

    assign dout = st_reg[NUM_W-1];

endmodule

@@ rtl/core/matrix3x3_inverse_top.sv @@
// An input beat reaches its result through 8 front stages, 48 divider stages and 1 output
// register. Throughput: one matrix per cycle while in_stall is low; the 48-stage restoring
// divider takes one beat per cycle. A skid register behind the output keeps the pipeline
// running for one stalled result.
// Reset clears the valid bits only; payload registers are not reset.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_top_assert.svh"
module matrix3x3_inverse_top
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [31:0] given_det,
    input  logic signed [23:0] m00,
    input  logic signed [23:0] m01,
    input  logic signed [23:0] m02,
    input  logic signed [23:0] m10,
    input  logic signed [23:0] m11,
    input  logic signed [23:0] m12,
    input  logic signed [23:0] m20,
    input  logic signed [23:0] m21,
    input  logic signed [23:0] m22,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] r00,
    output logic signed [31:0] r01,
    output logic signed [31:0] r02,
    output logic signed [31:0] r10,
    output logic signed [31:0] r11,
    output logic signed [31:0] r12,
    output logic signed [31:0] r20,
    output logic signed [31:0] r21,
    output logic signed [31:0] r22,
    output logic signed [31:0] determinant,
    output logic               singular,
    output logic               saturated
);

    localparam int SH    = 2 * FRAC_BITS;
    localparam int VLD_N = FRONT + NUM_W;

    logic                    en;
    logic [VLD_N-1:0]        vld_reg;
    logic                    out_vld_reg;
    logic                    skid_vld_reg;
    mi3_res_t                out_reg;
    mi3_res_t                skid_reg;
    mi3_res_t                fin;

    logic signed [M_W-1:0]   mi [NLANE];

    logic signed [PRD_W-1:0] pa_reg [NLANE];
    logic signed [PRD_W-1:0] pb_reg [NLANE];
    logic signed [M_W-1:0]   mrow1_reg [3];
    logic                    act1_reg;
    logic [RES_W-1:0]        gdet1_reg;

    logic signed [ADJ_W-1:0] adj2_reg [NLANE];
    logic signed [M_W-1:0]   mrow2_reg [3];
    logic                    act2_reg;
    logic [RES_W-1:0]        gdet2_reg;

    logic signed [ADJ_W-1:0] nabs [NLANE];
    logic signed [LO_W-1:0]  plo3_reg [3];
    logic signed [HI_W-1:0]  phi3_reg [3];
    mi3_side_t               side3_reg;
    mi3_side_t               side3_next;

    logic signed [DET_W-1:0] t4_reg [3];
    mi3_side_t               side4_reg;
    logic signed [DET_W-1:0] s5_reg;
    mi3_side_t               side5_reg;
    logic                    neg6_reg;
    logic [DET_W-1:0]        smag6_reg;
    mi3_side_t               side6_reg;
    logic                    neg7_reg;
    logic [DET_W-1:0]        rnd7_reg;
    mi3_side_t               side7_reg;

    logic [DET_W-1:0]        shifted;
    logic [RES_W:0]          detsat;
    logic [RES_W-1:0]        dv;
    mi3_div_t                divin_reg;
    mi3_div_t                divin_next;
    mi3_div_t                divout;

    logic [DIV_W-1:0]        dr   [NLANE];
    logic                    up   [NLANE];
    logic [NUM_W:0]          q1   [NLANE];
    logic [RES_W:0]          qsat [NLANE];
    logic                    clipacc;

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    assign mi[0] = m00;
    assign mi[1] = m01;
    assign mi[2] = m02;
    assign mi[3] = m10;
    assign mi[4] = m11;
    assign mi[5] = m12;
    assign mi[6] = m20;
    assign mi[7] = m21;
    assign mi[8] = m22;

    // Shift valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[VLD_N-2:0], in_valid};
        end
    end

    // Stage 1: the eighteen 2x2 minor products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                pa_reg[k] <= mi[CA[k]] * mi[CB[k]];
                pb_reg[k] <= mi[CC[k]] * mi[CD[k]];
            end
            for (int j = 0; j < 3; j++)
            begin
                mrow1_reg[j] <= mi[j];
            end
            act1_reg  <= action;
            gdet1_reg <= given_det;
        end
    end

    // Stage 2: cofactors, exact
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                adj2_reg[k] <= ADJ_W'(pa_reg[k]) - ADJ_W'(pb_reg[k]);
            end
            mrow2_reg <= mrow1_reg;
            act2_reg  <= act1_reg;
            gdet2_reg <= gdet1_reg;
        end
    end

    // Stage 3: split determinant products, numerator magnitudes
    always_comb
    begin
        side3_next.act  = act2_reg;
        side3_next.gdet = gdet2_reg;
        for (int k = 0; k < NLANE; k++)
        begin
            nabs[k]            = adj2_reg[k][ADJ_W-1] ? -adj2_reg[k] : adj2_reg[k];
            side3_next.nmag[k] = nabs[k][NUM_W-1:0];
            side3_next.nneg[k] = adj2_reg[k][ADJ_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo3_reg[j] <= mrow2_reg[j] * $signed({1'b0, adj2_reg[DJ[j]][31:0]});
                phi3_reg[j] <= mrow2_reg[j] * $signed(adj2_reg[DJ[j]][ADJ_W-1:32]);
            end
            side3_reg <= side3_next;
        end
    end

    // Stages 4 to 7: join partials, sum, take magnitude, add rounding half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t4_reg[j] <= (DET_W'(phi3_reg[j]) <<< 32) + DET_W'(plo3_reg[j]);
            end
            side4_reg <= side3_reg;
            s5_reg    <= t4_reg[0] + t4_reg[1] + t4_reg[2];
            side5_reg <= side4_reg;
            neg6_reg  <= s5_reg[DET_W-1];
            smag6_reg <= s5_reg[DET_W-1] ? DET_W'(-s5_reg) : DET_W'(s5_reg);
            side6_reg <= side5_reg;
            neg7_reg  <= neg6_reg;
            rnd7_reg  <= smag6_reg + (DET_W'(1) << (SH - 1));
            side7_reg <= side6_reg;
        end
    end

    // Stage 8: clip the determinant, pick the divisor, load the divider
    always_comb
    begin
        shifted = rnd7_reg >> SH;
        detsat  = sat32(neg7_reg, |shifted[DET_W-1:RES_W], shifted[RES_W-1:0]);
        dv      = side7_reg.act ? side7_reg.gdet : detsat[RES_W-1:0];
        divin_next.rem  = '0;
        divin_next.nq   = side7_reg.nmag;
        divin_next.d    = dv[RES_W-1] ? (~dv + 32'd1) : dv;
        divin_next.dneg = dv[RES_W-1];
        divin_next.nneg = side7_reg.nneg;
        divin_next.sing = (dv == '0);
        divin_next.det  = detsat[RES_W-1:0];
        divin_next.clip = detsat[RES_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            divin_reg <= divin_next;
        end
    end

    mi3_div u_div
    (
        .clk  (clk),
        .en   (en),
        .din  (divin_reg),
        .dout (divout)
    );

    // Round quotients half away from zero, sign and clip
    always_comb
    begin
        clipacc = 1'b0;
        for (int l = 0; l < NLANE; l++)
        begin
            dr[l]   = divout.d - divout.rem[l];
            up[l]   = (divout.rem[l] >= dr[l]);
            q1[l]   = {1'b0, divout.nq[l]} + (NUM_W+1)'(up[l]);
            qsat[l] = sat32(divout.nneg[l] ^ divout.dneg, |q1[l][NUM_W:RES_W],
                            q1[l][RES_W-1:0]);
            if (divout.sing)
            begin
                fin.r[l] = '0;
            end
            else
            begin
                fin.r[l] = qsat[l][RES_W-1:0];
                clipacc  = clipacc | qsat[l][RES_W];
            end
        end
        fin.det  = divout.det;
        fin.sing = divout.sing;
        fin.sat  = divout.clip | clipacc;
    end

    // Output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (!out_vld_reg || !out_stall)
            begin
                out_vld_reg <= vld_reg[VLD_N-1];
            end
            else if (vld_reg[VLD_N-1])
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!out_vld_reg || !out_stall)
            begin
                out_reg <= fin;
            end
            else
            begin
                skid_reg <= fin;
            end
        end
        else if (!out_stall)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign r00         = $signed(out_reg.r[0]);
    assign r01         = $signed(out_reg.r[1]);
    assign r02         = $signed(out_reg.r[2]);
    assign r10         = $signed(out_reg.r[3]);
    assign r11         = $signed(out_reg.r[4]);
    assign r12         = $signed(out_reg.r[5]);
    assign r20         = $signed(out_reg.r[6]);
    assign r21         = $signed(out_reg.r[7]);
    assign r22         = $signed(out_reg.r[8]);
    assign determinant = $signed(out_reg.det);
    assign singular    = out_reg.sing;
    assign saturated   = out_reg.sat;

    `MI3_ASSERT_IMPL(a_sing_zero, out_vld_reg && out_reg.sing, (out_reg.r == '0))
    `MI3_ASSERT_IMPL(a_skid_behind_out, skid_vld_reg, out_vld_reg)
    `MI3_ASSERT_NEXT(a_skid_catch, !skid_vld_reg && vld_reg[VLD_N-1] && out_vld_reg && out_stall, skid_vld_reg)

endmodule
